// ===== hdl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the sequence reorder buffer
// Store geometry, index width, status codes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package srb_pkg;

  // Reorder window; keep it a power of two so that the slot is the low bits
  localparam int unsigned Window     = 64;
  localparam int unsigned SlotBits   = $clog2(Window);
  localparam int unsigned IdxBits    = 32;
  localparam int unsigned PortIdxW   = 32;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned CntW       = $clog2(Window + 1);
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  typedef enum logic {
    OpComplete = 1'b0,
    OpFlush    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatRelease = 2'd0,
    StatClean   = 2'd1,
    StatDrop    = 2'd2,
    StatGap     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StIncr,
    StSend,
    StDrainRd,
    StDrainWr
  } state_e;

endpackage

// ===== hdl/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sequence_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_buffer: in-order release of tagged completions
// Stores early completions in a windowed slot store and releases them in
// sequence order, one word per output handshake.
// ----------------------------------------------------------------------------
// Completions arrive with a sequence index and a one-bit result, in any
// order, and leave strictly in index order. An arrival equal to the expected
// index is released, followed by every stored entry that continues the run
// without a gap; the final word of that run carries last. An arrival ahead of
// the expected index but inside the window is stored and produces no word.
// Arrivals outside the window, or whose slot is already taken, produce one
// status word (dropped) carrying the expected index. A flush produces one
// status word, clean or gap, and empties the store. The block works on one
// input word at a time and is not ready while it does so. A stored arrival
// passes through accept and check-and-store; a dropped one or a flush through
// accept, check and send, where the output may stall; a release through
// accept, check, increment and send, then a read, write and send step for each
// further entry drained. The single adder shared by the window check and the
// index increment and the registered payload RAM read set these steps.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer
  import srb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [PortIdxW-1:0] reply_index_i,
  input  logic                reply_result_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PortIdxW-1:0] out_index_o,
  output logic                out_result_o,
  output logic [1:0]          status_o,
  output logic                last_o
);

  // Sequencer state
  state_e state_q, state_d;

  // Control state
  logic [IdxBits-1:0] exp_q, exp_d;          // next index to release
  logic [Window-1:0]  valid_q, valid_d;      // slot holds an early arrival
  logic [CntW-1:0]    cnt_q, cnt_d;          // number of valid slots
  logic [NumW-1:0]    num_q, num_d;          // words emitted in this run

  // Captured input word
  op_e                op_q, op_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic               res_q, res_d;

  // Output register
  logic [PortIdxW-1:0] oidx_q, oidx_d;
  logic                ores_q, ores_d;
  status_e             ostat_q, ostat_d;
  logic                olast_q, olast_d;

  // Shared adder
  logic [IdxBits-1:0] add_a, add_b, sum;
  logic               add_cin;

  // Slot selects and check results
  logic [SlotBits-1:0] in_slot, exp_slot, nxt_slot;
  logic                in_window, chk_drop, chk_store;

  // Payload RAM
  logic ram_we, ram_rdata;

  // Shared unit: window distance in the check step, otherwise increment
  always_comb begin
    add_a   = exp_q;
    add_b   = '0;
    add_cin = 1'b1;
    if (state_q == StCheck) begin
      add_a = idx_q;
      add_b = ~exp_q;
    end
  end

  assign sum = add_a + add_b + IdxBits'(add_cin);

  assign in_slot   = idx_q[SlotBits-1:0];
  assign exp_slot  = exp_q[SlotBits-1:0];
  assign nxt_slot  = sum[SlotBits-1:0];
  assign in_window = (sum[IdxBits-1:SlotBits] == '0);
  assign chk_drop  = !in_window || valid_q[in_slot];
  assign chk_store = !chk_drop && (sum != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (op_q == OpFlush || chk_drop) begin
          state_d = StSend;
        end else if (chk_store) begin
          state_d = StIdle;
        end else begin
          state_d = StIncr;
        end
      end
      StIncr:    state_d = StSend;
      StSend: begin
        if (out_ready_i) begin
          state_d = olast_q ? StIdle : StDrainRd;
        end
      end
      StDrainRd: state_d = StDrainWr;
      StDrainWr: state_d = StSend;
      default:   state_d = StIdle;
    endcase
  end

  // Datapath and store updates
  always_comb begin
    exp_d   = exp_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    op_d    = op_q;
    idx_d   = idx_q;
    res_d   = res_q;
    oidx_d  = oidx_q;
    ores_d  = ores_q;
    ostat_d = ostat_q;
    olast_d = olast_q;
    ram_we  = 1'b0;
    case (state_q)
      StIdle: begin
        // Capture the incoming word
        if (in_valid_i) begin
          op_d  = op_e'(opcode_i);
          idx_d = IdxBits'(reply_index_i);
          res_d = reply_result_i;
        end
      end
      StCheck: begin
        if (op_q == OpFlush) begin
          // Report stranded entries, then drop the whole store
          oidx_d  = PortIdxW'(exp_q);
          ores_d  = 1'b0;
          ostat_d = (cnt_q != '0) ? StatGap : StatClean;
          olast_d = 1'b1;
          valid_d = '0;
          cnt_d   = '0;
        end else if (chk_drop) begin
          oidx_d  = PortIdxW'(exp_q);
          ores_d  = 1'b0;
          ostat_d = StatDrop;
          olast_d = 1'b1;
        end else if (chk_store) begin
          valid_d[in_slot] = 1'b1;
          cnt_d            = cnt_q + CntW'(1);
          ram_we           = 1'b1;
        end
      end
      StIncr: begin
        // Release the expected word; look ahead at the following slot
        oidx_d  = PortIdxW'(idx_q);
        ores_d  = res_q;
        ostat_d = StatRelease;
        olast_d = !valid_q[nxt_slot] || (NumW'(1) == NumW'(MaxResults));
        num_d   = NumW'(1);
        exp_d   = sum;
      end
      StDrainRd: begin
        valid_d[exp_slot] = 1'b0;
        cnt_d             = cnt_q - CntW'(1);
      end
      StDrainWr: begin
        oidx_d  = PortIdxW'(exp_q);
        ores_d  = ram_rdata;
        ostat_d = StatRelease;
        olast_d = !valid_q[nxt_slot] || ((num_q + NumW'(1)) == NumW'(MaxResults));
        num_d   = num_q + NumW'(1);
        exp_d   = sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      exp_q   <= '0;
      valid_q <= '0;
      cnt_q   <= '0;
      num_q   <= '0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      num_q   <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
    oidx_q  <= oidx_d;
    ores_q  <= ores_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  // Early-arrival payloads; read in the cycle before each drained word is built
  srb_ram #(
    .Width(1),
    .Depth(Window)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_slot),
    .wdata_i(res_q),
    .raddr_i(exp_slot),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = (state_q == StSend);
  assign out_index_o  = oidx_q;
  assign out_result_o = ores_q;
  assign status_o     = ostat_q;
  assign last_o       = olast_q;

`ifndef SYNTHESIS
  // Never take a new word while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output word pending");

  // The fill count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("slot count out of step with valid bits");

  // A word without last must be followed by a drain of the next slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> state_q == StDrainRd && valid_q[exp_slot])
    else $error("drain continued without a stored entry");
`endif

endmodule

// ===== test/sequence_reorder_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_tb: self-checking bench for in-order release
// Drives a directed table of completions and flushes, then shuffled runs of
// consecutive indices mixed with stray, stale and duplicate words. A local
// model of the window store predicts each word that no typed row gives. Both
// handshakes are throttled in turn.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_tb
  import srb_pkg::*;
();

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned RandomItems = 440;
  localparam int unsigned Segments    = 8;
  localparam int unsigned TailCycles  = 40;
  // The worst run (64-word drains behind stalled output, idle sender) stays
  // well below this.
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DirRows     = 21;

  // Idle and stall percentages per phase: none, sender, receiver, both.
  localparam int unsigned SendIdle [4] = '{0, 68, 0, 26};
  localparam int unsigned RecvStall[4] = '{0, 0, 68, 26};

  typedef struct packed {
    logic [PortIdxW-1:0] index;
    logic                result;
    status_e             status;
    logic                last;
  } word_t;

  typedef struct packed {
    op_e                 op;
    logic [PortIdxW-1:0] index;
    logic                result;
    logic                typed;
    word_t               want;
  } row_t;

  localparam word_t Untyped = '{index: '0, result: 1'b0, status: StatRelease, last: 1'b0};

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                opcode_i       = 1'b0;
  logic [PortIdxW-1:0] reply_index_i  = '0;
  logic                reply_result_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [PortIdxW-1:0] out_index_o;
  logic                out_result_o;
  logic [1:0]          status_o;
  logic                last_o;

  // Model state: next index to release and the early-arrival store.
  logic [IdxBits-1:0] next_seq;
  logic               held_valid [Window];
  logic               held_result[Window];

  word_t       run_words[$];   // words caused by the latest accepted input
  word_t       due_words[$];   // words still owed by the block, oldest first
  int unsigned words_sent;
  int unsigned mismatches;
  int unsigned cycles = 0;
  int unsigned send_idle_pct;
  int unsigned ready_stall_pct;

  row_t script[DirRows];

  sequence_reorder_buffer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .reply_index_i  (reply_index_i),
    .reply_result_i (reply_result_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_index_o    (out_index_o),
    .out_result_o   (out_result_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Work out the words one input causes, and advance the model state.
  function automatic void release_in_order(input op_e op, input logic [IdxBits-1:0] idx,
                                           input logic res);
    logic [IdxBits-1:0] ahead;
    int unsigned        slot;
    logic               stranded;
    word_t              w;
    run_words.delete();
    w = '{index: PortIdxW'(next_seq), result: 1'b0, status: StatClean, last: 1'b1};
    if (op == OpFlush) begin
      stranded = 1'b0;
      for (int i = 0; i < Window; i++) begin
        stranded |= held_valid[i];
        held_valid[i] = 1'b0;
      end
      w.status = stranded ? StatGap : StatClean;
      run_words.push_back(w);
      return;
    end
    ahead = idx - next_seq;
    slot  = int'(idx % Window);
    // Drop anything behind, too far ahead, or landing on a taken slot.
    if (ahead >= Window || held_valid[slot]) begin
      w.status = StatDrop;
      run_words.push_back(w);
      return;
    end
    if (ahead != 0) begin
      held_valid[slot]  = 1'b1;
      held_result[slot] = res;
      return;
    end
    run_words.push_back('{index: PortIdxW'(idx), result: res, status: StatRelease,
                          last: 1'b0});
    next_seq++;
    // Drain the run of stored entries that continues without a gap.
    while (run_words.size() < MaxResults && held_valid[int'(next_seq % Window)]) begin
      slot = int'(next_seq % Window);
      held_valid[slot] = 1'b0;
      run_words.push_back('{index: PortIdxW'(next_seq), result: held_result[slot],
                            status: StatRelease, last: 1'b0});
      next_seq++;
    end
    run_words[run_words.size() - 1].last = 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word, wait for its handshake, then book what it should cause.
  // Return in the step of acceptance so that a following word can keep valid
  // high without a bubble.
  task automatic send_word(input op_e op, input logic [PortIdxW-1:0] index,
                           input logic result, input logic typed, input word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    reply_index_i  <= index;
    reply_result_i <= result;
    do @(posedge clk_i); while (!in_ready_o);
    release_in_order(op, index[IdxBits-1:0], result);
    if (typed) begin
      due_words.push_back(want);
    end else begin
      foreach (run_words[i]) due_words.push_back(run_words[i]);
    end
    words_sent++;
  endtask

  // Output side: check each word taken, then pick the next ready level.
  always @(posedge clk_i) begin
    word_t want;
    if (out_valid_o && out_ready_i) begin
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word index %0h status %0d", out_index_o, status_o));
      end else begin
        want = due_words.pop_front();
        if (out_index_o !== want.index)
          report($sformatf("out_index %0h, want %0h", out_index_o, want.index));
        if (out_result_o !== want.result)
          report($sformatf("out_result %0b, want %0b at index %0h", out_result_o,
                           want.result, want.index));
        if (status_o !== want.status)
          report($sformatf("status %0d, want %0d at index %0h", status_o, want.status,
                           want.index));
        if (last_o !== want.last)
          report($sformatf("last %0b, want %0b at index %0h", last_o, want.last,
                           want.index));
      end
    end
    out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("sequence_reorder_buffer test failed");
      $finish;
    end
  end

  initial begin
    int unsigned   seg;
    int unsigned   span;
    int unsigned   gap_at;
    int unsigned   pick;
    int unsigned   tmp;
    int unsigned   j;
    int unsigned   order[$];
    logic [IdxBits-1:0] base;

    words_sent      = 0;
    mismatches      = 0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    next_seq        = '0;
    for (int i = 0; i < Window; i++) begin
      held_valid[i]  = 1'b0;
      held_result[i] = 1'b0;
    end

    // Directed table. Typed rows carry the word read straight off the spec;
    // the rest are left to the model. Comments give the expected index after.
    script = '{
      // flush on an empty store; index and result are ignored
      '{OpFlush,    32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd0, 1'b0, StatClean,   1'b1}},
      // first completion released at once (next 1)
      '{OpComplete, 32'd0,         1'b1, 1'b1, '{32'd0, 1'b1, StatRelease, 1'b1}},
      // already released: behind the window
      '{OpComplete, 32'd0,         1'b0, 1'b1, '{32'd1, 1'b0, StatDrop,    1'b1}},
      '{OpComplete, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd1, 1'b0, StatDrop,    1'b1}},
      // exactly one window ahead: just outside
      '{OpComplete, 32'd65,        1'b1, 1'b1, '{32'd1, 1'b0, StatDrop,    1'b1}},
      // last index inside the window: stored silently
      '{OpComplete, 32'd64,        1'b1, 1'b0, Untyped},
      // same slot again: duplicate
      '{OpComplete, 32'd64,        1'b0, 1'b1, '{32'd1, 1'b0, StatDrop,    1'b1}},
      '{OpComplete, 32'h8000_0001, 1'b0, 1'b1, '{32'd1, 1'b0, StatDrop,    1'b1}},
      '{OpComplete, 32'd3,         1'b0, 1'b0, Untyped},
      '{OpComplete, 32'd2,         1'b1, 1'b0, Untyped},
      // entries stranded behind index 1: gap, and the store empties
      '{OpFlush,    32'd0,         1'b0, 1'b1, '{32'd1, 1'b0, StatGap,     1'b1}},
      '{OpComplete, 32'd3,         1'b1, 1'b0, Untyped},
      '{OpComplete, 32'd2,         1'b0, 1'b0, Untyped},
      // releases 1, 2, 3 (next 4)
      '{OpComplete, 32'd1,         1'b1, 1'b0, Untyped},
      '{OpComplete, 32'd6,         1'b1, 1'b0, Untyped},
      // releases 4 alone, since 5 is missing (next 5)
      '{OpComplete, 32'd4,         1'b0, 1'b0, Untyped},
      // releases 5, 6 (next 7)
      '{OpComplete, 32'd5,         1'b1, 1'b0, Untyped},
      '{OpFlush,    32'd0,         1'b1, 1'b1, '{32'd7, 1'b0, StatClean,   1'b1}},
      '{OpComplete, 32'd7,         1'b0, 1'b1, '{32'd7, 1'b0, StatRelease, 1'b1}},
      '{OpComplete, 32'h7FFF_FFFF, 1'b1, 1'b1, '{32'd8, 1'b0, StatDrop,    1'b1}},
      '{OpFlush,    32'h0000_0000, 1'b0, 1'b1, '{32'd8, 1'b0, StatClean,   1'b1}}
    };

    // Hold reset, then release it on a rising edge.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i])
      send_word(script[i].op, script[i].index, script[i].result, script[i].typed,
                script[i].want);

    // Random part, in segments that cycle through the idling phases.
    for (seg = 0; seg < Segments; seg++) begin
      // Hold off until the block owes nothing before changing pace.
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (due_words.size() != 0);
      send_idle_pct   = SendIdle[seg % 4];
      ready_stall_pct = RecvStall[seg % 4];

      while (words_sent < DirRows + (seg + 1) * RandomItems / Segments) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          // Shuffled run of consecutive indices from the next expected one;
          // mostly short, sometimes the whole window.
          tmp  = $urandom_range(99);
          span = (tmp < 4) ? Window : (tmp < 14) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
          base = next_seq;
          order.delete();
          for (int i = 0; i < span; i++) order.push_back(i);
          for (int i = span - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          // Now and then lose one word so that the rest strand behind it.
          gap_at = ($urandom_range(99) < 15) ? $urandom_range(span - 1) : span;
          foreach (order[i]) begin
            if (order[i] != gap_at)
              send_word(OpComplete, PortIdxW'(base + IdxBits'(order[i])),
                        1'($urandom_range(1)), 1'b0, Untyped);
          end
          if (gap_at != span && $urandom_range(1) == 1)
            send_word(OpFlush, $urandom(), 1'($urandom_range(1)), 1'b0, Untyped);
        end else if (pick < 80) begin
          send_word(OpFlush, $urandom(), 1'($urandom_range(1)), 1'b0, Untyped);
        end else if (pick < 90) begin
          // Any index at all; almost always far out of the window.
          send_word(OpComplete, $urandom(), 1'($urandom_range(1)), 1'b0, Untyped);
        end else begin
          // Stale index, just behind the one expected.
          send_word(OpComplete, PortIdxW'(next_seq - IdxBits'($urandom_range(1, 200))),
                    1'($urandom_range(1)), 1'b0, Untyped);
        end
      end
    end

    // Drain: wait for every owed word, then a little longer for strays.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sequence_reorder_buffer test passed");
    end else begin
      $display("sequence_reorder_buffer test failed");
    end
    $finish;
  end

endmodule
